// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/rhsl_pkg.sv -----
// Types and constants of the RGB to hue, saturation and lightness pipeline.
// Depends on nothing.
package rhsl_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CH_W   = 8;
	localparam int HUE_W  = 16;
	localparam int SAT_W  = 17;
	localparam int SUM_W  = 9;
	localparam int HDEN_W = 11;
	localparam int HREM_W = 12;
	localparam int SREM_W = 9;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue_turn;
		logic [CH_W-1:0]  chroma_out;
		logic [SAT_W-1:0] sat_hsl;
		logic [SAT_W-1:0] sat_hsv;
		logic [CH_W-1:0]  light_level;
		logic [SUM_W-1:0] light_sum;
	} res_t;

	// Values that ride along the divider stages untouched
	typedef struct packed {
		logic [CH_W-1:0]  chroma;
		logic [SUM_W-1:0] sum;
		logic             grey;
	} side_t;

	// Partial remainders and divisors of the three divisions
	typedef struct packed {
		logic [HREM_W-1:0] hue_r;
		logic [HDEN_W-1:0] hue_d;
		logic [SREM_W-1:0] hsl_r;
		logic [CH_W-1:0]   hsl_d;
		logic [SREM_W-1:0] hsv_r;
		logic [CH_W-1:0]   hsv_d;
	} div_rem_t;
endpackage

// ----- hw/rtl/rhsl_front.sv -----
// First pipeline stage: max, min, chroma, sums and hue numerator.
// Depends on rhsl_pkg.
module rhsl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  rhsl_pkg::pix_t    pixel,
	output logic              vld_s1,
	output rhsl_pkg::side_t   side_s1,
	output rhsl_pkg::div_rem_t rem_s1
);
	import rhsl_pkg::*;

	logic [CH_W-1:0]   r, g, b, hi, lo, c;
	logic [SUM_W-1:0]  sum, spread;
	logic [CH_W-1:0]   den;
	logic [HREM_W-1:0] num, c12;
	div_rem_t          rem;
	side_t             side;

	// Find extremes and derived quantities
	always_comb begin
		r = pixel.red;
		g = pixel.green;
		b = pixel.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		c = hi - lo;
		sum = {1'b0, hi} + {1'b0, lo};
		spread = (sum >= SUM_W'(255)) ? sum - SUM_W'(255) : SUM_W'(255) - sum;
		den = CH_W'(SUM_W'(255) - spread);
		c12 = HREM_W'(c);
		// Hue sector numerator, red sector wrapped into range
		if (hi == r) begin
			if (g >= b) num = HREM_W'(g) - HREM_W'(b);
			else num = HREM_W'(6) * c12 - (HREM_W'(b) - HREM_W'(g));
		end else if (hi == g) begin
			num = HREM_W'(2) * c12 + HREM_W'(b) - HREM_W'(r);
		end else begin
			num = HREM_W'(4) * c12 + HREM_W'(r) - HREM_W'(g);
		end
		rem.hue_r = num;
		rem.hue_d = HDEN_W'(HREM_W'(6) * c12);
		rem.hsl_r = SREM_W'(c);
		rem.hsl_d = den;
		rem.hsv_r = SREM_W'(c);
		rem.hsv_d = hi;
		side.chroma = c;
		side.sum = sum;
		side.grey = (c == '0);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= vld;
	end

	// Hold payload
	always_ff @(posedge clk) begin
		side_s1 <= side;
		rem_s1 <= rem;
	end
endmodule

// ----- hw/rtl/rhsl_div_stage.sv -----
// One quotient bit of the three fraction divisions, registered.
// Depends on rhsl_pkg.
module rhsl_div_stage #(
	parameter int FRAC_BITS = rhsl_pkg::FRAC_BITS_DEF,
	parameter bit FIRST = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_i,
	input  rhsl_pkg::side_t      side_i,
	input  rhsl_pkg::div_rem_t   rem_i,
	input  logic [FRAC_BITS:0]   hue_q_i,
	input  logic [FRAC_BITS:0]   hsl_q_i,
	input  logic [FRAC_BITS:0]   hsv_q_i,
	output logic                 vld_o,
	output rhsl_pkg::side_t      side_o,
	output rhsl_pkg::div_rem_t   rem_o,
	output logic [FRAC_BITS:0]   hue_q_o,
	output logic [FRAC_BITS:0]   hsl_q_o,
	output logic [FRAC_BITS:0]   hsv_q_o
);
	import rhsl_pkg::*;

	logic [HREM_W-1:0] hue_s;
	logic [SREM_W-1:0] hsl_s, hsv_s;
	logic              hue_ge, hsl_ge, hsv_ge;
	div_rem_t          rem_n;

	// Shift (not in the first stage), compare and subtract each remainder
	always_comb begin
		hue_s = FIRST ? rem_i.hue_r : {rem_i.hue_r[HREM_W-2:0], 1'b0};
		hsl_s = FIRST ? rem_i.hsl_r : {rem_i.hsl_r[SREM_W-2:0], 1'b0};
		hsv_s = FIRST ? rem_i.hsv_r : {rem_i.hsv_r[SREM_W-2:0], 1'b0};
		hue_ge = hue_s >= HREM_W'(rem_i.hue_d);
		hsl_ge = hsl_s >= SREM_W'(rem_i.hsl_d);
		hsv_ge = hsv_s >= SREM_W'(rem_i.hsv_d);
		rem_n = rem_i;
		rem_n.hue_r = hue_ge ? hue_s - HREM_W'(rem_i.hue_d) : hue_s;
		rem_n.hsl_r = hsl_ge ? hsl_s - SREM_W'(rem_i.hsl_d) : hsl_s;
		rem_n.hsv_r = hsv_ge ? hsv_s - SREM_W'(rem_i.hsv_d) : hsv_s;
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_o <= 1'b0;
		else vld_o <= vld_i;
	end

	// Hold payload
	always_ff @(posedge clk) begin
		side_o <= side_i;
		rem_o <= rem_n;
		hue_q_o <= {hue_q_i[FRAC_BITS-1:0], hue_ge};
		hsl_q_o <= {hsl_q_i[FRAC_BITS-1:0], hsl_ge};
		hsv_q_o <= {hsv_q_i[FRAC_BITS-1:0], hsv_ge};
	end
endmodule

// ----- hw/rtl/rgb_to_hue_sat_light_top.sv -----
// RGB pixel to hue, HSL/HSV saturation and lightness. Accepts one pixel on
// every clock (busy is never raised) and presents each result on result for
// exactly one cycle with result_valid high, after the pixel has passed the
// registered max/min front stage and the quotient bit stages of the
// FRAC_BITS + 1 bit fraction dividers, which compute all three divisions
// side by side. The receiver cannot stall the pipeline.
// Depends on rhsl_pkg, rhsl_front, rhsl_div_stage.
module rgb_to_hue_sat_light_top #(
	parameter int FRAC_BITS = rhsl_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rhsl_pkg::pix_t  pixel,
	output logic            result_valid,
	output rhsl_pkg::res_t  result
);
	import rhsl_pkg::*;

	localparam int NST = FRAC_BITS + 1;

	logic                vld_s [NST+1];
	side_t               side_s [NST+1];
	div_rem_t            rem_s [NST+1];
	logic [FRAC_BITS:0]  hue_q [NST+1];
	logic [FRAC_BITS:0]  hsl_q [NST+1];
	logic [FRAC_BITS:0]  hsv_q [NST+1];
	logic [HUE_W-1:0]    hue_w;
	logic [SAT_W-1:0]    hsl_w, hsv_w;

	assign busy = 1'b0;

	rhsl_front u_front (
		.clk(clk), .arst_n(arst_n), .vld(start), .pixel(pixel),
		.vld_s1(vld_s[0]), .side_s1(side_s[0]), .rem_s1(rem_s[0])
	);

	assign hue_q[0] = '0;
	assign hsl_q[0] = '0;
	assign hsv_q[0] = '0;

	// One stage per quotient bit
	for (genvar i = 0; i < NST; i++) begin : g_div
		rhsl_div_stage #(.FRAC_BITS(FRAC_BITS), .FIRST(i == 0)) u_stage (
			.clk(clk), .arst_n(arst_n),
			.vld_i(vld_s[i]), .side_i(side_s[i]), .rem_i(rem_s[i]),
			.hue_q_i(hue_q[i]), .hsl_q_i(hsl_q[i]), .hsv_q_i(hsv_q[i]),
			.vld_o(vld_s[i+1]), .side_o(side_s[i+1]), .rem_o(rem_s[i+1]),
			.hue_q_o(hue_q[i+1]), .hsl_q_o(hsl_q[i+1]), .hsv_q_o(hsv_q[i+1])
		);
	end

	// Fit quotients to the field widths
	if (FRAC_BITS + 1 >= SAT_W) begin : g_wide
		assign hsl_w = hsl_q[NST][SAT_W-1:0];
		assign hsv_w = hsv_q[NST][SAT_W-1:0];
	end else begin : g_narrow
		assign hsl_w = SAT_W'(hsl_q[NST]);
		assign hsv_w = SAT_W'(hsv_q[NST]);
	end
	if (FRAC_BITS + 1 >= HUE_W) begin : g_hwide
		assign hue_w = hue_q[NST][HUE_W-1:0];
	end else begin : g_hnarrow
		assign hue_w = HUE_W'(hue_q[NST]);
	end

	// Drop quotients of grey pixels
	always_comb begin
		result.hue_turn    = side_s[NST].grey ? '0 : hue_w;
		result.sat_hsl     = side_s[NST].grey ? '0 : hsl_w;
		result.sat_hsv     = side_s[NST].grey ? '0 : hsv_w;
		result.chroma_out  = side_s[NST].chroma;
		result.light_level = side_s[NST].sum[SUM_W-1:1];
		result.light_sum   = side_s[NST].sum;
	end

	assign result_valid = vld_s[NST];
endmodule

// ----- hw/rtl/rhsl_checker.sv -----
// Port-level checks of the pixel pipeline, bound to the top level.
// Depends on rhsl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rhsl_checker #(
	parameter int FRAC_BITS = rhsl_pkg::FRAC_BITS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input rhsl_pkg::pix_t  pixel,
	input logic            result_valid,
	input rhsl_pkg::res_t  result
);
	import rhsl_pkg::*;

	localparam int LAT = FRAC_BITS + 2;

	`ASSERT_NEVER(a_no_busy, clk, arst_n, busy, "busy raised")
	`ASSERT_IMPL(a_latency, clk, arst_n, start, ##LAT result_valid, "result missing")
	`ASSERT_IMPL(a_grey, clk, arst_n, result_valid && result.chroma_out == '0, result.hue_turn == '0 && result.sat_hsl == '0 && result.sat_hsv == '0, "grey pixel not zeroed")
	`ASSERT_IMPL(a_light, clk, arst_n, result_valid, result.light_sum[SUM_W-1:1] == result.light_level && result.light_sum >= SUM_W'(result.chroma_out), "lightness inconsistent")
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, result_valid, $past(start, LAT), "result without pixel")
endmodule

bind rgb_to_hue_sat_light_top rhsl_checker #(.FRAC_BITS(FRAC_BITS)) u_rhsl_checker (.*);

// ----- tb/rgb_to_hue_sat_light_top_test.sv -----
// Testbench for rgb_to_hue_sat_light_top: drives pixels, predicts hue, saturations
// and lightness in integer arithmetic and checks each result transaction in order.
// Depends on rhsl_pkg and rgb_to_hue_sat_light_top.
`timescale 1ns / 100ps

module rgb_to_hue_sat_light_top_test;
	import rhsl_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	pix_t pixel = '0;
	logic busy;
	logic result_valid;
	res_t result;

	pix_t pending_pixels[$];
	res_t expected_colours[$];
	int mismatches = 0;
	int pixels_sent = 0;
	int results_seen = 0;
	int gap_left = 0;
	bit drain_hold = 1'b0;
	bit stimulus_done = 1'b0;

	rgb_to_hue_sat_light_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel(pixel), .result_valid(result_valid), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out hue, saturations and lightness of one pixel
	function automatic res_t convert_pixel(pix_t p);
		res_t r;
		longint unsigned rr, gg, bb, hi, lo, c, sum, spread, hden, num, one;
		one = 64'd1 << FRAC;
		rr = 64'(p.red);
		gg = 64'(p.green);
		bb = 64'(p.blue);
		hi = rr; lo = rr;
		if (gg > hi) hi = gg;
		if (bb > hi) hi = bb;
		if (gg < lo) lo = gg;
		if (bb < lo) lo = bb;
		c = hi - lo;
		sum = hi + lo;
		spread = (sum >= 255) ? sum - 255 : 255 - sum;
		hden = 255 - spread;
		r = '0;
		if (c != 0) begin
			if (hi == rr) begin
				if (gg >= bb) num = gg - bb;
				else num = 6 * c - (bb - gg);
			end else if (hi == gg) begin
				num = 2 * c + bb - rr;
			end else begin
				num = 4 * c + rr - gg;
			end
			r.hue_turn = HUE_W'((num * one) / (6 * c));
			r.sat_hsl = (hden == 0) ? '0 : SAT_W'((c * one) / hden);
			r.sat_hsv = SAT_W'((c * one) / hi);
		end
		r.chroma_out = CH_W'(c);
		r.light_level = CH_W'(sum >> 1);
		r.light_sum = SUM_W'(sum);
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
		mismatches++;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 9) != 0) return int'($urandom_range(0, 3));
		return int'($urandom_range(10, 40));
	endfunction

	// Drive the next pixel when the gap has run out and the block is free
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_colours.push_back(convert_pixel(pixel));
				pixels_sent++;
			end
			if (start && busy) begin
				// hold the transaction until it is taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_pixels.size() > 0 && !drain_hold) begin
				pixel <= pending_pixels.pop_front();
				start <= 1'b1;
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_valid) begin
			results_seen++;
			if (expected_colours.size() == 0) begin
				$display("unexpected result at %0t", $time);
				mismatches++;
			end else begin
				want = expected_colours.pop_front();
				if (result.hue_turn !== want.hue_turn)
					report_mismatch("hue_turn", int'(result.hue_turn),
						int'(want.hue_turn));
				if (result.chroma_out !== want.chroma_out)
					report_mismatch("chroma_out", int'(result.chroma_out),
						int'(want.chroma_out));
				if (result.sat_hsl !== want.sat_hsl)
					report_mismatch("sat_hsl", int'(result.sat_hsl),
						int'(want.sat_hsl));
				if (result.sat_hsv !== want.sat_hsv)
					report_mismatch("sat_hsv", int'(result.sat_hsv),
						int'(want.sat_hsv));
				if (result.light_level !== want.light_level)
					report_mismatch("light_level", int'(result.light_level),
						int'(want.light_level));
				if (result.light_sum !== want.light_sum)
					report_mismatch("light_sum", int'(result.light_sum),
						int'(want.light_sum));
			end
		end
	end

	function automatic pix_t make_pixel(int r, int g, int b);
		pix_t p;
		p.red = CH_W'(r); p.green = CH_W'(g); p.blue = CH_W'(b);
		return p;
	endfunction

	// Fill the pixel queue and follow the run to its end
	initial begin
		int i;
		int mode;
		int base;
		// black, white, greys, primaries, secondaries, ties and wrap of red sector
		pending_pixels.push_back(make_pixel(0, 0, 0));
		pending_pixels.push_back(make_pixel(255, 255, 255));
		pending_pixels.push_back(make_pixel(128, 128, 128));
		pending_pixels.push_back(make_pixel(255, 0, 0));
		pending_pixels.push_back(make_pixel(0, 255, 0));
		pending_pixels.push_back(make_pixel(0, 0, 255));
		pending_pixels.push_back(make_pixel(255, 255, 0));
		pending_pixels.push_back(make_pixel(0, 255, 255));
		pending_pixels.push_back(make_pixel(255, 0, 255));
		pending_pixels.push_back(make_pixel(255, 0, 1));
		pending_pixels.push_back(make_pixel(200, 10, 200));
		pending_pixels.push_back(make_pixel(10, 200, 200));
		pending_pixels.push_back(make_pixel(1, 0, 0));
		pending_pixels.push_back(make_pixel(255, 254, 254));
		pending_pixels.push_back(make_pixel(128, 127, 127));
		pending_pixels.push_back(make_pixel(127, 128, 128));
		pending_pixels.push_back(make_pixel(0, 1, 2));
		pending_pixels.push_back(make_pixel(170, 85, 255));
		pending_pixels.push_back(make_pixel(254, 255, 0));
		pending_pixels.push_back(make_pixel(85, 170, 170));
		for (i = 0; i < 1400; i++) begin
			mode = int'($urandom_range(0, 9));
			if (mode < 6) begin
				pending_pixels.push_back(make_pixel(int'($urandom_range(0, 255)),
					int'($urandom_range(0, 255)), int'($urandom_range(0, 255))));
			end else if (mode < 8) begin
				// near-grey pixels stress tiny chroma
				base = int'($urandom_range(0, 255));
				pending_pixels.push_back(make_pixel(base,
					(base + int'($urandom_range(0, 2))) & 8'hFF,
					(base + 256 - int'($urandom_range(0, 2))) & 8'hFF));
			end else begin
				pending_pixels.push_back(make_pixel(int'($urandom_range(0, 1)) * 255,
					int'($urandom_range(0, 1)) * 255, int'($urandom_range(0, 255))));
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// pause the sender once until the pipeline has drained
		wait (pixels_sent >= 700);
		@(posedge clk);
		drain_hold <= 1'b1;
		wait (!start && expected_colours.size() == 0);
		@(posedge clk);
		drain_hold <= 1'b0;
		wait (pending_pixels.size() == 0);
		@(posedge clk);
		wait (!start);
		@(posedge clk);
		wait (expected_colours.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
		$display("Checked %0d results from %0d pixels: greys, black, white, primaries,",
			results_seen, pixels_sent);
		$display("hue sector ties and wrap, near-grey and saturated random pixels.");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a run that hangs
	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end
endmodule
